// File: rtl/core/kts_pkg.sv
`default_nettype none

package kts_pkg;

    // Token kinds
    typedef logic [3:0] t_kind;
    localparam t_kind KIND_KEYWORD = 4'd0;
    localparam t_kind KIND_IDENT   = 4'd1;
    localparam t_kind KIND_ASSIGN  = 4'd2;
    localparam t_kind KIND_COMPARE = 4'd3;
    localparam t_kind KIND_SEMI    = 4'd4;
    localparam t_kind KIND_LBRACE  = 4'd5;
    localparam t_kind KIND_RBRACE  = 4'd6;
    localparam t_kind KIND_LPAREN  = 4'd7;
    localparam t_kind KIND_RPAREN  = 4'd8;
    localparam t_kind KIND_STRING  = 4'd9;

    // Scan modes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_IDLE   = 2'd0;
    localparam t_mode MODE_IDENT  = 2'd1;
    localparam t_mode MODE_STRING = 2'd2;

    // Pending operator codes
    typedef logic [1:0] t_op;
    localparam t_op OP_NONE = 2'd0;
    localparam t_op OP_EQ   = 2'd1;
    localparam t_op OP_LT   = 2'd2;
    localparam t_op OP_GT   = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;

    // First five letters of an identifier, element 0 is the first letter
    localparam int HEAD_LEN = 5;
    typedef logic [HEAD_LEN-1:0][7:0] t_head;

    // Keyword table: if, while, for, else, elif, int, main
    localparam int KW_NUM = 7;
    localparam t_head KW_TEXT [KW_NUM] = '{
        40'h0000006669, 40'h656C696877, 40'h0000726F66, 40'h0065736C65,
        40'h0066696C65, 40'h0000746E69, 40'h006E69616D
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd2, 3'd5, 3'd3, 3'd4, 3'd4, 3'd3, 3'd4};

    // True when the head with length n spells a keyword
    function automatic logic kw_match(input t_head head, input logic [2:0] n);
        logic hit;
        logic eq;
        hit = 1'b0;
        for (int k = 0; k < KW_NUM; k++) begin
            eq = (n == KW_LEN[k]);
            for (int i = 0; i < HEAD_LEN; i++) begin
                if ((3'(i) < KW_LEN[k]) && (head[i] != KW_TEXT[k][i])) begin
                    eq = 1'b0;
                end
            end
            hit = hit | eq;
        end
        return hit;
    endfunction

    // Printed character of a pending operator
    function automatic logic [7:0] op_char(input t_op op);
        logic [7:0] c;
        unique case (op)
            OP_LT:   c = CH_LT;
            OP_GT:   c = CH_GT;
            default: c = CH_EQ;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/kts_if.sv
`default_nettype none

// Source byte channel
interface kts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_input;

    modport source (output valid, output source_byte, output end_of_input, input ready);
    modport sink   (input valid, input source_byte, input end_of_input, output ready);
endinterface

// Token character channel
interface kts_out_if;
    logic                valid;
    logic                ready;
    kts_pkg::t_kind      token_kind;
    logic [7:0]          token_char;
    logic                token_last;

    modport source (output valid, output token_kind, output token_char, output token_last,
                    input ready);
    modport sink   (input valid, input token_kind, input token_char, input token_last,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/kts_ram.sv
`default_nettype none

// Single-port-write, single-port-read RAM with registered read data
module kts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                       i_clk,
    input  wire                       i_wr_en,
    input  wire [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire [WIDTH-1:0]           i_wr_data,
    input  wire                       i_rd_en,
    input  wire [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/keyword_token_scanner.sv
// Keyword token scanner: byte-serial lexer for a small C-like language.
// i_src carries one source byte per item (or an end_of_input marker);
// o_tok carries one token character per item with its kind, and token_last
// on the final character of each token. Both use valid/ready handshakes.
// Letters are gathered into a text RAM; a non-letter ends the run and the
// word leaves as a keyword or identifier. = < > wait one byte for a
// following '='. ; { } ( ) leave at once; strings leave quotes included.
// A byte is taken, then decoded in the next cycle; after decode each token
// character is emitted from a state of its own. Buffered text (identifiers,
// string bodies) is read back from the RAM one character at a time: each is
// read in S_RD through the single RAM read port with its registered data,
// then emitted in S_EMIT before the next one is read.
// A result sits in an output register; while the receiver stalls it holds
// and the scanner waits with the next character.
// Reset (i_rst_n low, synchronous) returns to idle with no pending token;
// the text RAM needs no clearing. end_of_input flushes any open token and
// returns to the same state.
`default_nettype none

module keyword_token_scanner #(
    parameter int IDENT_BUF  = 50,
    parameter int STRING_BUF = 64
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    kts_in_if.sink  i_src,
    kts_out_if.source o_tok
);
    import kts_pkg::*;

    localparam int BUF_DEPTH = (IDENT_BUF > STRING_BUF) ? IDENT_BUF : STRING_BUF;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int LEN_W     = ADDR_W + 1;
    localparam logic [LEN_W-1:0] ID_LIM  = LEN_W'(IDENT_BUF - 1);
    localparam logic [LEN_W-1:0] STR_LIM = LEN_W'(STRING_BUF - 2);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PROC  = 4'd1;
    localparam logic [3:0] S_OP1   = 4'd2;
    localparam logic [3:0] S_CMP1  = 4'd3;
    localparam logic [3:0] S_CMP2  = 4'd4;
    localparam logic [3:0] S_PUNCT = 4'd5;
    localparam logic [3:0] S_OPEN  = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_CLOSE = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [7:0]        r_byte, n_byte;
    logic              r_eoi, n_eoi;
    t_mode             r_mode, n_mode;
    t_op               r_op, n_op;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [ADDR_W-1:0] r_idx, n_idx;
    t_kind             r_kind, n_kind;
    t_head             r_head, n_head;

    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [7:0]        r_out_char;
    logic              r_out_last;

    logic              w_slot;
    logic              w_emit;
    t_kind             w_e_kind;
    logic [7:0]        w_e_char;
    logic              w_e_last;
    logic              w_letter;
    logic              w_is_kw;
    logic [LEN_W-1:0]  w_id_len;
    logic [LEN_W-1:0]  w_idx_inc;

    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic              w_rd_en;
    logic [7:0]        w_rd_data;

    // Text buffer
    kts_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_text (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_byte),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    assign i_src.ready      = (r_state == S_IDLE);
    assign o_tok.valid      = r_out_valid;
    assign o_tok.token_kind = r_out_kind;
    assign o_tok.token_char = r_out_char;
    assign o_tok.token_last = r_out_last;

    assign w_slot    = !r_out_valid || o_tok.ready;
    assign w_letter  = ((r_byte >= 8'h41) && (r_byte <= 8'h5A))
                    || ((r_byte >= 8'h61) && (r_byte <= 8'h7A));
    assign w_is_kw   = (r_len <= LEN_W'(HEAD_LEN)) && kw_match(r_head, r_len[2:0]);
    assign w_id_len  = (r_mode == MODE_IDENT) ? r_len : '0;
    assign w_idx_inc = {1'b0, r_idx} + LEN_W'(1);

    // Sequencer: decode a byte, then emit its token characters
    always_comb begin
        n_state   = r_state;
        n_byte    = r_byte;
        n_eoi     = r_eoi;
        n_mode    = r_mode;
        n_op      = r_op;
        n_len     = r_len;
        n_idx     = r_idx;
        n_kind    = r_kind;
        n_head    = r_head;
        w_emit    = 1'b0;
        w_e_kind  = r_kind;
        w_e_char  = r_byte;
        w_e_last  = 1'b1;
        w_wr_en   = 1'b0;
        w_wr_addr = r_len[ADDR_W-1:0];
        w_rd_en   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_src.valid) begin
                    n_byte  = i_src.source_byte;
                    n_eoi   = i_src.end_of_input;
                    n_state = S_PROC;
                end
            end

            S_PROC: begin
                priority if (r_eoi) begin
                    // flush whatever is open
                    priority if (r_mode == MODE_STRING) begin
                        n_kind  = KIND_STRING;
                        n_state = S_OPEN;
                    end else if (r_mode == MODE_IDENT) begin
                        n_kind  = w_is_kw ? KIND_KEYWORD : KIND_IDENT;
                        n_idx   = '0;
                        n_state = S_RD;
                    end else if (r_op != OP_NONE) begin
                        n_state = S_OP1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (r_mode == MODE_STRING) begin
                    if (r_byte == CH_QUOTE) begin
                        n_kind  = KIND_STRING;
                        n_state = S_OPEN;
                    end else begin
                        if (r_len < STR_LIM) begin
                            w_wr_en = 1'b1;
                            n_len   = r_len + LEN_W'(1);
                        end
                        n_state = S_IDLE;
                    end
                end else if (r_op != OP_NONE) begin
                    n_state = (r_byte == CH_EQ) ? S_CMP1 : S_OP1;
                end else if (w_letter) begin
                    n_mode = MODE_IDENT;
                    n_len  = w_id_len;
                    if (w_id_len < ID_LIM) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = w_id_len[ADDR_W-1:0];
                        n_len     = w_id_len + LEN_W'(1);
                        if (w_id_len < LEN_W'(HEAD_LEN)) begin
                            n_head[w_id_len[2:0]] = r_byte;
                        end
                    end
                    n_state = S_IDLE;
                end else if (r_mode == MODE_IDENT) begin
                    // word ends; the byte is decoded again afterwards
                    n_kind  = w_is_kw ? KIND_KEYWORD : KIND_IDENT;
                    n_idx   = '0;
                    n_state = S_RD;
                end else begin
                    n_state = S_IDLE;
                    unique case (r_byte)
                        CH_EQ:     n_op = OP_EQ;
                        CH_LT:     n_op = OP_LT;
                        CH_GT:     n_op = OP_GT;
                        CH_SEMI: begin
                            n_kind  = KIND_SEMI;
                            n_state = S_PUNCT;
                        end
                        CH_LBRACE: begin
                            n_kind  = KIND_LBRACE;
                            n_state = S_PUNCT;
                        end
                        CH_RBRACE: begin
                            n_kind  = KIND_RBRACE;
                            n_state = S_PUNCT;
                        end
                        CH_LPAREN: begin
                            n_kind  = KIND_LPAREN;
                            n_state = S_PUNCT;
                        end
                        CH_RPAREN: begin
                            n_kind  = KIND_RPAREN;
                            n_state = S_PUNCT;
                        end
                        CH_QUOTE: begin
                            n_mode = MODE_STRING;
                            n_len  = '0;
                        end
                        default: ;
                    endcase
                end
            end

            // lone operator; the byte is decoded again afterwards unless it ended the input
            S_OP1: begin
                w_emit   = 1'b1;
                w_e_kind = (r_op == OP_EQ) ? KIND_ASSIGN : KIND_COMPARE;
                w_e_char = op_char(r_op);
                if (w_slot) begin
                    n_op    = OP_NONE;
                    n_state = r_eoi ? S_IDLE : S_PROC;
                end
            end

            // two-character comparator
            S_CMP1: begin
                w_emit   = 1'b1;
                w_e_kind = KIND_COMPARE;
                w_e_char = op_char(r_op);
                w_e_last = 1'b0;
                if (w_slot) begin
                    n_state = S_CMP2;
                end
            end

            S_CMP2: begin
                w_emit   = 1'b1;
                w_e_kind = KIND_COMPARE;
                w_e_char = CH_EQ;
                if (w_slot) begin
                    n_op    = OP_NONE;
                    n_state = S_IDLE;
                end
            end

            S_PUNCT: begin
                w_emit = 1'b1;
                if (w_slot) begin
                    n_state = S_IDLE;
                end
            end

            S_OPEN: begin
                w_emit   = 1'b1;
                w_e_char = CH_QUOTE;
                w_e_last = 1'b0;
                if (w_slot) begin
                    n_idx   = '0;
                    n_state = (r_len == '0) ? S_CLOSE : S_RD;
                end
            end

            S_RD: begin
                w_rd_en = 1'b1;
                n_state = S_EMIT;
            end

            // buffered character from the RAM
            S_EMIT: begin
                w_emit   = 1'b1;
                w_e_char = w_rd_data;
                w_e_last = (r_kind != KIND_STRING) && (w_idx_inc == r_len);
                if (w_slot) begin
                    if (w_idx_inc == r_len) begin
                        if (r_kind == KIND_STRING) begin
                            n_state = S_CLOSE;
                        end else begin
                            n_len   = '0;
                            n_mode  = MODE_IDLE;
                            n_state = r_eoi ? S_IDLE : S_PROC;
                        end
                    end else begin
                        n_idx   = r_idx + ADDR_W'(1);
                        n_state = S_RD;
                    end
                end
            end

            S_CLOSE: begin
                w_emit   = 1'b1;
                w_e_char = CH_QUOTE;
                if (w_slot) begin
                    n_len   = '0;
                    n_mode  = MODE_IDLE;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_IDLE;
            r_op        <= OP_NONE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_op    <= n_op;
            r_len   <= n_len;
            if (w_emit && w_slot) begin
                r_out_valid <= 1'b1;
            end else if (o_tok.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_byte <= n_byte;
        r_eoi  <= n_eoi;
        r_idx  <= n_idx;
        r_kind <= n_kind;
        r_head <= n_head;
        if (w_emit && w_slot) begin
            r_out_kind <= w_e_kind;
            r_out_char <= w_e_char;
            r_out_last <= w_e_last;
        end
    end

endmodule

`default_nettype wire

// File: test/keyword_token_scanner_checker.sv
`default_nettype none

// Watches both channels, predicts the token characters of every accepted
// source item and compares them in order with what the scanner sends.
module keyword_token_scanner_checker #(
    parameter int IDENT_BUF  = 50,
    parameter int STRING_BUF = 64
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    kts_in_if    i_src,
    kts_out_if   i_tok,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_char_count,
    output int   o_token_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import kts_pkg::*;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] chr;
        logic       last;
    } t_tok_char;

    // Token characters still owed by the scanner, oldest first
    t_tok_char expected_chars [$];

    // Shadow of the scanner state
    logic [7:0] text_mem [64];
    int         text_len;
    t_mode      mode;
    t_op        pend_op;

    string keyword_list [7] = '{"if", "while", "for", "else", "elif", "int", "main"};

    int fail_count    = 0;
    int pending_count = 0;
    int char_count    = 0;
    int token_count   = 0;

    assign o_fail_count  = fail_count;
    assign o_pending     = pending_count;
    assign o_char_count  = char_count;
    assign o_token_count = token_count;

    function automatic bit spells_keyword();
        bit hit;
        bit same;
        hit = 1'b0;
        for (int k = 0; k < 7; k++) begin
            same = (keyword_list[k].len() == text_len);
            for (int i = 0; same && i < keyword_list[k].len(); i++) begin
                if (text_mem[i] != 8'(keyword_list[k][i])) begin
                    same = 1'b0;
                end
            end
            hit = hit | same;
        end
        return hit;
    endfunction

    function automatic logic [7:0] op_text(input t_op op);
        case (op)
            OP_LT:   return CH_LT;
            OP_GT:   return CH_GT;
            default: return CH_EQ;
        endcase
    endfunction

    task automatic owe(input t_kind kind, input logic [7:0] chr, input logic last);
        t_tok_char tc;
        tc.kind = kind;
        tc.chr  = chr;
        tc.last = last;
        expected_chars.push_back(tc);
    endtask

    task automatic clear_state();
        text_len = 0;
        mode     = MODE_IDLE;
        pend_op  = OP_NONE;
    endtask

    // Gathered letters leave as a keyword or an identifier
    task automatic flush_word();
        t_kind kind;
        kind = spells_keyword() ? KIND_KEYWORD : KIND_IDENT;
        for (int i = 0; i < text_len; i++) begin
            owe(kind, text_mem[i], (i == text_len - 1));
        end
        text_len = 0;
        mode     = MODE_IDLE;
    endtask

    // String leaves with both quotes around its body
    task automatic flush_quoted();
        owe(KIND_STRING, CH_QUOTE, 1'b0);
        for (int i = 0; i < text_len; i++) begin
            owe(KIND_STRING, text_mem[i], 1'b0);
        end
        owe(KIND_STRING, CH_QUOTE, 1'b1);
        text_len = 0;
        mode     = MODE_IDLE;
    endtask

    task automatic flush_op();
        owe((pend_op == OP_EQ) ? KIND_ASSIGN : KIND_COMPARE, op_text(pend_op), 1'b1);
        pend_op = OP_NONE;
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic eoi);
        bit letter;
        letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
        if (eoi) begin
            // end of text: flush whatever is open, then back to idle
            if (mode == MODE_STRING) begin
                flush_quoted();
            end else if (mode == MODE_IDENT) begin
                flush_word();
            end else if (pend_op != OP_NONE) begin
                flush_op();
            end
            clear_state();
        end else if (mode == MODE_STRING) begin
            // body bytes beyond the buffer are dropped until the closing quote
            if (b == CH_QUOTE) begin
                flush_quoted();
            end else if (text_len < STRING_BUF - 2) begin
                text_mem[text_len] = b;
                text_len++;
            end
        end else if (pend_op != OP_NONE && b == CH_EQ) begin
            owe(KIND_COMPARE, op_text(pend_op), 1'b0);
            owe(KIND_COMPARE, CH_EQ, 1'b1);
            pend_op = OP_NONE;
        end else begin
            if (pend_op != OP_NONE) begin
                flush_op();
            end
            if (letter) begin
                if (mode != MODE_IDENT) begin
                    mode     = MODE_IDENT;
                    text_len = 0;
                end
                if (text_len < IDENT_BUF - 1) begin
                    text_mem[text_len] = b;
                    text_len++;
                end
            end else begin
                if (mode == MODE_IDENT) begin
                    flush_word();
                end
                case (b)
                    CH_EQ:     pend_op = OP_EQ;
                    CH_LT:     pend_op = OP_LT;
                    CH_GT:     pend_op = OP_GT;
                    CH_SEMI:   owe(KIND_SEMI, b, 1'b1);
                    CH_LBRACE: owe(KIND_LBRACE, b, 1'b1);
                    CH_RBRACE: owe(KIND_RBRACE, b, 1'b1);
                    CH_LPAREN: owe(KIND_LPAREN, b, 1'b1);
                    CH_RPAREN: owe(KIND_RPAREN, b, 1'b1);
                    CH_QUOTE: begin
                        mode     = MODE_STRING;
                        text_len = 0;
                    end
                    default: ;
                endcase
            end
        end
    endtask

    // Compare outgoing items first, then predict from the incoming one
    always @(posedge i_clk) begin : watch
        t_tok_char got;
        t_tok_char want;
        if (!i_rst_n) begin
            clear_state();
            expected_chars.delete();
        end else begin
            if (i_tok.valid && i_tok.ready) begin
                got.kind = i_tok.token_kind;
                got.chr  = i_tok.token_char;
                got.last = i_tok.token_last;
                char_count++;
                if (got.last) begin
                    token_count++;
                end
                if (expected_chars.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected token item: kind %0d char %h last %b",
                             $time, got.kind, got.chr, got.last);
                end else begin
                    want = expected_chars.pop_front();
                    if (got.kind !== want.kind || got.chr !== want.chr
                            || got.last !== want.last) begin
                        fail_count++;
                        $display("%0t: token mismatch: expected kind %0d char %h last %b,",
                                 $time, want.kind, want.chr, want.last,
                                 " got kind %0d char %h last %b",
                                 got.kind, got.chr, got.last);
                    end
                end
            end
            if (i_src.valid && i_src.ready) begin
                scan_byte(i_src.source_byte, i_src.end_of_input);
            end
        end
        pending_count <= expected_chars.size();
    end

endmodule

`default_nettype wire

// File: test/keyword_token_scanner_test.sv
`default_nettype none

module keyword_token_scanner_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kts_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 330;
    localparam int SETTLE_CYCLES = 160;

    logic i_clk;
    logic i_rst_n;

    kts_in_if  src_if ();
    kts_out_if tok_if ();

    int fail_count;
    int pending_count;
    int char_count;
    int token_count;

    int item_count  = 0;
    int burst_left  = 0;
    int cycle_count = 0;

    string keyword_list [7] = '{"if", "while", "for", "else", "elif", "int", "main"};
    logic [7:0] punct_list [5] = '{CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN};
    logic [7:0] op_list [3] = '{CH_EQ, CH_LT, CH_GT};

    keyword_token_scanner DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_if),
        .o_tok   (tok_if)
    );

    keyword_token_scanner_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_src         (src_if),
        .i_tok         (tok_if),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count),
        .o_char_count  (char_count),
        .o_token_count (token_count)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Sender: bursts of random length, random gaps between them
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(8, 20);
                default: gap = $urandom_range(1, 3);
            endcase
            if (gap > 0) begin
                src_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        src_if.valid        <= 1'b1;
        src_if.source_byte  <= b;
        src_if.end_of_input <= eoi;
        @(posedge i_clk);
        while (!src_if.ready) @(posedge i_clk);
        item_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(8'(s[i]), 1'b0);
        end
    endtask

    // Hold the sender until every owed token item has come out
    task automatic drain();
        src_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
        return base + 8'($urandom_range(0, 25));
    endfunction

    // Any byte but the closing quote
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // One well-formed token, a broken one, noise, or an end of text
    task automatic send_random_token(input int index);
        int choice;
        int n;
        string w;
        logic [7:0] b;
        bit near;
        choice = $urandom_range(0, 99);
        if (index % 90 == 30) begin
            // identifier around and past the buffer limit
            n = $urandom_range(47, 58);
            repeat (n) send_byte(random_letter(), 1'b0);
            send_byte(8'h20, 1'b0);
        end else if (index % 90 == 70) begin
            // string around and past the buffer limit
            send_byte(CH_QUOTE, 1'b0);
            n = $urandom_range(60, 70);
            repeat (n) send_byte(body_byte(), 1'b0);
            send_byte(CH_QUOTE, 1'b0);
        end else if (choice < 22) begin
            // keyword, sometimes with a capital or an extra letter
            w = keyword_list[$urandom_range(0, 6)];
            near = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < w.len(); i++) begin
                b = 8'(w[i]);
                if (near && i == 0) b = b - 8'h20;
                send_byte(b, 1'b0);
            end
            if ($urandom_range(0, 5) == 0) send_byte(random_letter(), 1'b0);
            if ($urandom_range(0, 2) != 0) send_byte(8'h20, 1'b0);
        end else if (choice < 36) begin
            n = $urandom_range(1, 8);
            repeat (n) send_byte(random_letter(), 1'b0);
            if ($urandom_range(0, 1)) send_byte(8'h20, 1'b0);
        end else if (choice < 52) begin
            send_byte(op_list[$urandom_range(0, 2)], 1'b0);
            case ($urandom_range(0, 3))
                0: send_byte(CH_EQ, 1'b0);
                1: begin
                    send_byte(CH_EQ, 1'b0);
                    send_byte(CH_EQ, 1'b0);
                end
                default: ;
            endcase
        end else if (choice < 64) begin
            send_byte(punct_list[$urandom_range(0, 4)], 1'b0);
        end else if (choice < 76) begin
            send_byte(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 10);
            repeat (n) send_byte(body_byte(), 1'b0);
            if ($urandom_range(0, 6) != 0) send_byte(CH_QUOTE, 1'b0);
        end else if (choice < 93) begin
            case ($urandom_range(0, 2))
                0:       send_byte($urandom_range(0, 1) ? 8'h20 : 8'h0A, 1'b0);
                1:       send_byte(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
                default: send_byte(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end else begin
            // end of text, often with a token still open
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // Receiver: the stall pattern changes after each span of random length
    initial begin : receiver
        int style;
        int span;
        int k;
        tok_if.ready <= 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(50, 300);
            for (k = 0; k < span; k++) begin
                @(posedge i_clk);
                case (style)
                    0:       tok_if.ready <= 1'b1;
                    1:       tok_if.ready <= 1'($urandom_range(0, 1));
                    2:       tok_if.ready <= ($urandom_range(0, 3) == 0);
                    default: tok_if.ready <= (k % 8 >= 6);
                endcase
            end
        end
    end

    // Cycle limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d token items still owed",
                 cycle_count, pending_count);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int tok_index;
        int start_items;
        src_if.valid        <= 1'b0;
        src_if.source_byte  <= 8'h00;
        src_if.end_of_input <= 1'b0;
        i_rst_n             <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: keyword, identifier, every operator shape, punctuation,
        // a string, extreme bytes and a lone operator flushed by end of text
        send_text("if(a>=B){x=y;}<\"q\"==");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_GT, 1'b0);
        send_byte(8'hA5, 1'b1);
        drain();

        // Random token streams in three phases, fully drained between them
        start_items = item_count;
        tok_index = 0;
        for (int phase = 1; phase <= 3; phase++) begin
            while (item_count - start_items < phase * RANDOM_ITEMS / 3) begin
                send_random_token(tok_index);
                tok_index++;
            end
            drain();
        end

        $display("Sent %0d source items; checked %0d token characters in %0d tokens",
                 item_count, char_count, token_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d token items never arrived",
                     fail_count, pending_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
